[rtl/core/tkrc_pkg.sv]
// Shared types and constants for the keyed TTL result cache.
package tkrc_pkg;

    localparam int ENTRIES_DEF = 4;
    localparam int SLOT_W      = 4;
    localparam int KEY_W       = 64;
    localparam int PAY_W       = 64;
    localparam int TIME_W      = 48;
    localparam int TTL_W       = 32;
    localparam int OP_W        = 2;

    localparam logic [TTL_W-1:0] TTL_RESET = 32'd300000;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   op;
        logic              skip;
        logic              found;
        logic              have_old;
        logic [SLOT_W-1:0] pick;
        logic [TIME_W-1:0] oldest;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [PAY_W-1:0]  hit_payload;
    } t_tok;

    // Entry update broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              clr;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [TIME_W-1:0] tstamp;
    } t_wr;

endpackage

[rtl/core/tkrc_if.sv]
// Handshake channel interfaces for the keyed TTL result cache.
interface tkrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [tkrc_pkg::OP_W-1:0]     op;
    logic [tkrc_pkg::KEY_W-1:0]    key;
    logic [tkrc_pkg::PAY_W-1:0]    payload;
    logic [tkrc_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, op, key, payload, now_ms, input ready);
    modport sink   (input valid, op, key, payload, now_ms, output ready);
endinterface

interface tkrc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [tkrc_pkg::PAY_W-1:0]    hit_payload;
    logic                          written;
    logic [tkrc_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, hit, hit_payload, written, slot, input ready);
    modport sink   (input valid, hit, hit_payload, written, slot, output ready);
endinterface

interface tkrc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tkrc_pkg::TTL_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/tkrc_cell.sv]
// One cache entry cell: holds an entry and advances the search token by one place.
module tkrc_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tkrc_pkg::TTL_W-1:0]  i_ttl,
    input  tkrc_pkg::t_tok              i_tok,
    input  tkrc_pkg::t_wr               i_wr,
    output tkrc_pkg::t_tok              o_tok
);

    localparam logic [tkrc_pkg::SLOT_W-1:0] MY_SLOT = tkrc_pkg::SLOT_W'(IDX);

    logic                         r_vld;
    logic [tkrc_pkg::KEY_W-1:0]   r_key;
    logic [tkrc_pkg::PAY_W-1:0]   r_payload;
    logic [tkrc_pkg::TIME_W-1:0]  r_time;
    tkrc_pkg::t_tok               r_tok;
    tkrc_pkg::t_tok               n_tok;
    logic [tkrc_pkg::TIME_W-1:0]  age;
    logic                         match;
    logic                         fresh;

    assign age   = i_tok.now - r_time;
    assign match = r_vld && (r_key == i_tok.key);
    assign fresh = age < tkrc_pkg::TIME_W'(i_ttl);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.skip && !i_tok.found) begin
            case (i_tok.op)
                tkrc_pkg::OP_LOOKUP: begin
                    if (match && fresh) begin
                        n_tok.found       = 1'b1;
                        n_tok.pick        = MY_SLOT;
                        n_tok.hit_payload = r_payload;
                    end
                end
                tkrc_pkg::OP_STORE: begin
                    if (!r_vld || match) begin
                        n_tok.found = 1'b1;
                        n_tok.pick  = MY_SLOT;
                    end else if (!i_tok.have_old || (r_time < i_tok.oldest)) begin
                        n_tok.have_old = 1'b1;
                        n_tok.oldest   = r_time;
                        n_tok.pick     = MY_SLOT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.clr) begin
                r_vld <= 1'b0;
            end else if (i_wr.en && (i_wr.slot == MY_SLOT)) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.clr && (i_wr.slot == MY_SLOT)) begin
            r_key     <= i_wr.key;
            r_payload <= i_wr.payload;
            r_time    <= i_wr.tstamp;
        end
    end

    assign o_tok = r_tok;

endmodule

[rtl/core/ttl_keyed_result_cache.sv]
// Top level of the keyed TTL result cache: controller, TTL register and cell chain.
// Path: head token register, cell chain registers, result register, output register.
// One item at a time, taken only when idle; the search token walks the cell chain.
// A stalled result is held in the output register while the next item is taken.
// Reset: synchronous, active low; clears all valid bits, sets TTL to 300000 ms.
module ttl_keyed_result_cache #(
    parameter int ENTRIES = tkrc_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkrc_in_if.sink     i_in,
    tkrc_out_if.source  o_out,
    tkrc_cfg_if.sink    i_cfg
);

    tkrc_pkg::t_state             r_state;
    tkrc_pkg::t_state             n_state;
    logic [tkrc_pkg::TTL_W-1:0]   r_ttl;
    tkrc_pkg::t_tok               r_tok;
    tkrc_pkg::t_tok               n_tok;
    tkrc_pkg::t_tok               r_res;
    logic [tkrc_pkg::PAY_W-1:0]   r_payload;
    tkrc_pkg::t_tok               chain [ENTRIES+1];
    tkrc_pkg::t_wr                wr;

    logic                         r_out_vld;
    logic                         r_hit;
    logic [tkrc_pkg::PAY_W-1:0]   r_hit_payload;
    logic                         r_written;
    logic [tkrc_pkg::SLOT_W-1:0]  r_slot;

    logic                         in_xfer;
    logic                         res_load;
    logic                         res_hit;
    logic                         res_wen;

    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == tkrc_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_tok          = '0;
        n_tok.vld      = in_xfer;
        n_tok.op       = i_in.op;
        n_tok.key      = i_in.key;
        n_tok.now      = i_in.now_ms;
        n_tok.skip     = (r_ttl == '0) &&
                         ((i_in.op == tkrc_pkg::OP_LOOKUP) || (i_in.op == tkrc_pkg::OP_STORE));
    end

    assign chain[0] = r_tok;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tkrc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ttl   (r_ttl),
            .i_tok   (chain[g]),
            .i_wr    (wr),
            .o_tok   (chain[g+1])
        );
    end

    assign res_hit = (r_res.op == tkrc_pkg::OP_LOOKUP) && r_res.found;
    assign res_wen = (r_res.op == tkrc_pkg::OP_STORE) && !r_res.skip &&
                     (r_res.found || r_res.have_old);

    always_comb begin
        n_state  = r_state;
        res_load = 1'b0;
        wr       = '0;
        wr.slot    = r_res.pick;
        wr.key     = r_res.key;
        wr.payload = r_payload;
        wr.tstamp  = r_res.now;
        unique case (r_state)
            tkrc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = tkrc_pkg::ST_SCAN;
                end
            end
            tkrc_pkg::ST_SCAN: begin
                if (chain[ENTRIES].vld) begin
                    n_state = tkrc_pkg::ST_FINISH;
                end
            end
            tkrc_pkg::ST_FINISH: begin
                if (!r_out_vld || o_out.ready) begin
                    res_load = 1'b1;
                    wr.en    = res_wen;
                    wr.clr   = (r_res.op == tkrc_pkg::OP_CLEAR);
                    n_state  = tkrc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tkrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tkrc_pkg::ST_IDLE;
            r_ttl     <= tkrc_pkg::TTL_RESET;
            r_tok     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tok   <= n_tok;
            if (i_cfg.valid && i_cfg.ready) begin
                r_ttl <= i_cfg.data;
            end
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_payload <= i_in.payload;
        end
        if ((r_state == tkrc_pkg::ST_SCAN) && chain[ENTRIES].vld) begin
            r_res <= chain[ENTRIES];
        end
        if (res_load) begin
            r_hit         <= res_hit;
            r_hit_payload <= res_hit ? r_res.hit_payload : '0;
            r_written     <= res_wen;
            r_slot        <= (res_hit || res_wen) ? r_res.pick : '0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.hit         = r_hit;
    assign o_out.hit_payload = r_hit_payload;
    assign o_out.written     = r_written;
    assign o_out.slot        = r_slot;

endmodule

[rtl/core/tkrc_chk.sv]
// Port-level assertion checker for the keyed TTL result cache, with its bind.
module tkrc_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tkrc_in_if.sink    i_in,
    tkrc_out_if.source o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=>
            (o_out.valid && $stable(o_out.hit) && $stable(o_out.hit_payload) &&
             $stable(o_out.written) && $stable(o_out.slot)))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit) |-> (o_out.hit_payload == '0))
        else $error("payload not zero on a miss");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.hit && o_out.written))
        else $error("hit and written both set");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit && !o_out.written) |-> (o_out.slot == '0))
        else $error("slot not zero without hit or write");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in progress");

endmodule

bind ttl_keyed_result_cache tkrc_chk u_tkrc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

[sim/ttl_keyed_result_cache_tb.sv]
// Self-checking testbench for the keyed TTL result cache: directed table, then random phases.
module ttl_keyed_result_cache_tb;
    import tkrc_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int POOL_N  = 6;
    localparam int N_PHASES = 9;
    localparam int TAIL_CYCLES = ENTRIES + 12;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_ONES  = '1;
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum logic {ROW_ITEM, ROW_TTL} t_row_kind;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [TIME_W-1:0] now_ms;
    } t_query;

    typedef struct {
        logic              hit;
        logic [PAY_W-1:0]  hit_payload;
        logic              written;
        logic [SLOT_W-1:0] slot;
    } t_answer;

    typedef struct {
        t_row_kind         kind;
        logic [TTL_W-1:0]  ttl;
        t_query            q;
        bit                typed;
        t_answer           want;
    } t_row;

    localparam t_answer NO_ANSWER = '{1'b0, '0, 1'b0, '0};

    localparam logic [TTL_W-1:0] PH_TTL [N_PHASES] = '{
        32'd300000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000,
        32'd7, 32'd300000, 32'hFFFF_FFFF, 32'd65536
    };
    localparam t_idle PH_MODE [N_PHASES] = '{
        IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_BOTH,
        IDLE_SEND, IDLE_BOTH, IDLE_NONE, IDLE_RECV
    };
    localparam int PH_ITEMS [N_PHASES] = '{250, 150, 250, 100, 250, 150, 200, 150, 100};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tkrc_in_if  in_ch ();
    tkrc_out_if res_ch ();
    tkrc_cfg_if cfg_ch ();

    ttl_keyed_result_cache DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predicted cache contents
    logic [KEY_W-1:0]  ent_key  [ENTRIES];
    logic [PAY_W-1:0]  ent_pay  [ENTRIES];
    logic [TIME_W-1:0] ent_time [ENTRIES];
    bit                ent_vld  [ENTRIES];
    logic [TTL_W-1:0]  ttl_cur;

    t_answer           pending_answers [$];
    t_row              dir_rows [$];
    logic [KEY_W-1:0]  key_pool [POOL_N];
    logic [TIME_W-1:0] time_base;
    int                send_pct = 0;
    int                recv_pct = 0;
    int                errors = 0;

    function automatic t_answer cache_access(t_query q);
        t_answer a;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        int pick;
        bit direct;
        bit have_old;
        a = NO_ANSWER;
        pick = 0;
        direct = 1'b0;
        have_old = 1'b0;
        oldest = '0;
        case (q.op)
            OP_LOOKUP: if (ttl_cur != 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    age = q.now_ms - ent_time[i];
                    if (!a.hit && ent_vld[i] && ent_key[i] == q.key && age < ttl_cur) begin
                        a.hit = 1'b1;
                        a.hit_payload = ent_pay[i];
                        a.slot = SLOT_W'(i);
                    end
                end
            end
            OP_STORE: if (ttl_cur != 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!direct) begin
                        if (!ent_vld[i] || ent_key[i] == q.key) begin
                            pick = i;
                            direct = 1'b1;
                        end else if (!have_old || ent_time[i] < oldest) begin
                            oldest = ent_time[i];
                            pick = i;
                            have_old = 1'b1;
                        end
                    end
                end
                ent_key[pick] = q.key;
                ent_pay[pick] = q.payload;
                ent_time[pick] = q.now_ms;
                ent_vld[pick] = 1'b1;
                a.written = 1'b1;
                a.slot = SLOT_W'(pick);
            end
            OP_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) ent_vld[i] = 1'b0;
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_row drow(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                  logic [PAY_W-1:0] pay, logic [TIME_W-1:0] now_ms);
        t_row r;
        r.kind = ROW_ITEM;
        r.ttl = '0;
        r.q = '{op, key, pay, now_ms};
        r.typed = 1'b0;
        r.want = NO_ANSWER;
        return r;
    endfunction

    function automatic t_row trow(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                  logic [PAY_W-1:0] pay, logic [TIME_W-1:0] now_ms,
                                  logic hit, logic [PAY_W-1:0] hit_pay, logic written,
                                  logic [SLOT_W-1:0] slot);
        t_row r;
        r = drow(op, key, pay, now_ms);
        r.typed = 1'b1;
        r.want = '{hit, hit_pay, written, slot};
        return r;
    endfunction

    function automatic t_row crow(logic [TTL_W-1:0] ttl);
        t_row r;
        r = drow(OP_LOOKUP, '0, '0, '0);
        r.kind = ROW_TTL;
        r.ttl = ttl;
        return r;
    endfunction

    // Time walks forward in steps scaled to the lifetime, with ties, jumps, wraps and slips back
    function automatic t_query next_query();
        t_query q;
        logic [63:0] r64;
        logic [31:0] span;
        int sel;
        span = (ttl_cur == 0) ? 32'd4096 : (ttl_cur >> 1) + 32'd1;
        r64 = rand64();
        q.now_ms = time_base;
        case ($urandom_range(0, 19))
            0: begin
                time_base = r64[TIME_W-1:0];
                q.now_ms = time_base;
            end
            1: begin
                time_base = TIME_MAX - TIME_W'($urandom_range(0, span));
                q.now_ms = time_base;
            end
            2: q.now_ms = time_base - TIME_W'($urandom_range(0, span));
            3, 4: ;
            default: begin
                time_base = time_base + TIME_W'($urandom_range(0, span));
                q.now_ms = time_base;
            end
        endcase
        q.payload = rand64();
        q.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N-1)] : rand64();
        sel = $urandom_range(0, 99);
        if (sel < 47)       q.op = OP_LOOKUP;
        else if (sel < 90)  q.op = OP_STORE;
        else if (sel < 93)  q.op = OP_CLEAR;
        else if (sel < 96)  q.op = OP_UNUSED;
        else begin
            q.op = OP_LOOKUP;
            q.key = rand64();
        end
        return q;
    endfunction

    task automatic send_query(t_query q, bit typed, t_answer want);
        t_answer pred;
        while ($urandom_range(0, 99) < send_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= q.op;
        in_ch.key     <= q.key;
        in_ch.payload <= q.payload;
        in_ch.now_ms  <= q.now_ms;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = cache_access(q);
        pending_answers.push_back(typed ? want : pred);
    endtask

    task automatic set_ttl(logic [TTL_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        ttl_cur = v;
    endtask

    task automatic check_answer();
        t_answer want;
        if (pending_answers.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("unexpected result: hit=%0d pay=%h wr=%0d slot=%0d",
                         res_ch.hit, res_ch.hit_payload, res_ch.written, res_ch.slot);
        end else begin
            want = pending_answers.pop_front();
            if (res_ch.hit !== want.hit || res_ch.hit_payload !== want.hit_payload ||
                res_ch.written !== want.written || res_ch.slot !== want.slot) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: exp hit=%0d pay=%h wr=%0d slot=%0d, got hit=%0d pay=%h wr=%0d slot=%0d",
                             want.hit, want.hit_payload, want.written, want.slot,
                             res_ch.hit, res_ch.hit_payload, res_ch.written, res_ch.slot);
            end
        end
    endtask

    initial begin : result_sink
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) check_answer();
            res_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_pct);
        end
    end

    initial begin : stimulus
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_LOOKUP;
        in_ch.key     <= '0;
        in_ch.payload <= '0;
        in_ch.now_ms  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;

        ttl_cur = TTL_RESET;
        time_base = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            ent_key[i] = '0;
            ent_pay[i] = '0;
            ent_time[i] = '0;
            ent_vld[i] = 1'b0;
        end

        // after reset, extremes, lifetime edges, replacement, clear, zero, unit and maximum lifetimes
        dir_rows.push_back(trow(OP_LOOKUP, '0, '0, '0, 0, '0, 0, 0));
        dir_rows.push_back(trow(OP_UNUSED, KEY_ONES, '1, TIME_MAX, 0, '0, 0, 0));
        dir_rows.push_back(trow(OP_STORE, '0, '1, '0, 0, '0, 1, 0));
        dir_rows.push_back(trow(OP_STORE, KEY_ONES, '0, TIME_MAX, 0, '0, 1, 1));
        dir_rows.push_back(trow(OP_LOOKUP, '0, '0, 48'd299999, 1, '1, 0, 0));
        dir_rows.push_back(trow(OP_LOOKUP, '0, '0, 48'd300000, 0, '0, 0, 0));
        dir_rows.push_back(trow(OP_LOOKUP, KEY_ONES, '0, 48'd299998, 1, '0, 0, 1));
        dir_rows.push_back(trow(OP_LOOKUP, KEY_ONES, '0, 48'd299999, 0, '0, 0, 0));
        dir_rows.push_back(trow(OP_STORE, 64'h0123_4567_89AB_CDEF, 64'hA5A5_A5A5_A5A5_A5A5,
                                48'd5, 0, '0, 1, 2));
        dir_rows.push_back(trow(OP_STORE, 64'hFEDC_BA98_7654_3210, 64'h5A5A_5A5A_5A5A_5A5A,
                                48'd5, 0, '0, 1, 3));
        dir_rows.push_back(trow(OP_STORE, 64'h8000_0000_0000_0001, 64'h1111, 48'd7, 0, '0, 1, 0));
        dir_rows.push_back(trow(OP_STORE, 64'h7FFF_FFFF_FFFF_FFFE, 64'h2222, 48'd7, 0, '0, 1, 2));
        dir_rows.push_back(trow(OP_STORE, KEY_ONES, 64'h3333, 48'd8, 0, '0, 1, 1));
        dir_rows.push_back(drow(OP_LOOKUP, 64'hFEDC_BA98_7654_3210, '0, 48'd6));
        dir_rows.push_back(drow(OP_LOOKUP, KEY_ONES, '0, 48'd9));
        dir_rows.push_back(crow(32'd0));
        dir_rows.push_back(trow(OP_STORE, 64'h42, 64'h42, 48'd10, 0, '0, 0, 0));
        dir_rows.push_back(trow(OP_LOOKUP, 64'hFEDC_BA98_7654_3210, '0, 48'd6, 0, '0, 0, 0));
        dir_rows.push_back(trow(OP_CLEAR, KEY_ONES, '1, TIME_MAX, 0, '0, 0, 0));
        dir_rows.push_back(crow(TTL_RESET));
        dir_rows.push_back(trow(OP_LOOKUP, 64'hFEDC_BA98_7654_3210, '0, 48'd6, 0, '0, 0, 0));
        dir_rows.push_back(crow(32'd1));
        dir_rows.push_back(trow(OP_STORE, 64'h42, 64'hDEAD_BEEF, 48'd1000, 0, '0, 1, 0));
        dir_rows.push_back(trow(OP_LOOKUP, 64'h42, '0, 48'd1000, 1, 64'hDEAD_BEEF, 0, 0));
        dir_rows.push_back(trow(OP_LOOKUP, 64'h42, '0, 48'd1001, 0, '0, 0, 0));
        dir_rows.push_back(crow(32'hFFFF_FFFF));
        dir_rows.push_back(drow(OP_LOOKUP, 64'h42, '0, 48'd1000 + 48'hFFFF_FFFE));
        dir_rows.push_back(drow(OP_LOOKUP, 64'h42, '0, 48'd1000 + 48'hFFFF_FFFF));
        dir_rows.push_back(drow(OP_STORE, 64'h42, '1, 48'h0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_TTL) set_ttl(dir_rows[r].ttl);
            else send_query(dir_rows[r].q, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_ttl(PH_TTL[p]);
            send_pct = (PH_MODE[p] == IDLE_SEND) ? 72 : (PH_MODE[p] == IDLE_BOTH) ? 6 : 0;
            recv_pct = (PH_MODE[p] == IDLE_RECV) ? 72 : (PH_MODE[p] == IDLE_BOTH) ? 6 : 0;
            for (int k = 0; k < POOL_N; k++) key_pool[k] = rand64();
            repeat (PH_ITEMS[p]) send_query(next_query(), 1'b0, NO_ANSWER);
        end

        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
